// ===== design/lbfg_pkg.sv =====
// Shared types and constants for the load-based frequency governor.
`timescale 1ns / 1ps
package lbfg_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LOAD_W      = 7;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [TIME_W-1:0] MIN_ELAPSED_US = 32'd1000;
  localparam logic [TIME_W-1:0] DOWN_HOLD_US   = 32'd99000;

  // Shared bit-serial divider: 39-bit dividend covers both 100*busy_us and
  // cur_freq*load at the widest frequency field.
  localparam int unsigned DIV_NUM_W = 39;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } step_dir_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FREQ_MIN   = 3'd0,
    REG_FREQ_MAX   = 3'd1,
    REG_IDEAL_FREQ = 3'd2,
    REG_STEP_UP    = 3'd3,
    REG_STEP_DOWN  = 3'd4,
    REG_LOAD_HIGH  = 3'd5,
    REG_LOAD_LOW   = 3'd6,
    REG_UP_HOLD_US = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LDIV,
    ST_DECIDE,
    ST_PMUL,
    ST_PDIV,
    ST_PFIX,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_div_start;
    logic div_step;
    logic decide;
    logic prop_start;
    logic prop_fix;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic short_tick;
    logic need_prop;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/lbfg_ctrl.sv =====
// Sequencing state machine for the governor: one request at a time.
`timescale 1ns / 1ps
module lbfg_ctrl import lbfg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.short_tick) begin
          state_next = ST_FINISH;
        end else begin
          cmd.load_div_start = 1'b1;
          cnt_next           = '0;
          state_next         = ST_LDIV;
        end
      end
      ST_LDIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = ST_DECIDE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.need_prop ? ST_PMUL : ST_FINISH;
      end
      ST_PMUL: begin
        cmd.prop_start = 1'b1;
        cnt_next       = '0;
        state_next     = ST_PDIV;
      end
      ST_PDIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = ST_PFIX;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PFIX: begin
        cmd.prop_fix = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  a_cnt_only_in_div: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> (state == ST_LDIV || state == ST_PDIV))
    else $error("iteration count live outside a divide phase");

  a_ldiv_to_decide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LDIV && cnt == DIV_LAST) |=> state == ST_DECIDE)
    else $error("load divide did not hand over to decision");

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a pending one");

endmodule

// ===== design/lbfg_dp.sv =====
// Governor datapath: settings, captured request, shared divider, decision and result register.
`timescale 1ns / 1ps
module lbfg_dp import lbfg_pkg::*; #(
  parameter int unsigned FREQ_W = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [TIME_W-1:0]      idle_delta_us,
  input  logic [TIME_W-1:0]      elapsed_delta_us,
  input  logic [TIME_W-1:0]      now_us,
  input  logic [FREQ_W-1:0]      cur_freq,
  input  logic                   many_runnable,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [FREQ_W-1:0]      out_chosen_freq,
  output logic                   out_changed,
  output step_dir_t              out_step_dir,
  output logic [LOAD_W-1:0]      out_load_pct,
  output logic                   out_skipped,
  output logic                   out_keep_sampling
);

  localparam logic [FREQ_W-1:0] FMIN_RST  = FREQ_W'(32'd122880);
  localparam logic [FREQ_W-1:0] FMAX_RST  = FREQ_W'(32'd4194303);
  localparam logic [FREQ_W-1:0] IDEAL_RST = FREQ_W'(32'd800000);
  localparam logic [FREQ_W-1:0] SUP_RST   = FREQ_W'(32'd128000);
  localparam logic [FREQ_W-1:0] SDN_RST   = FREQ_W'(32'd256000);
  localparam int unsigned       PROD_W    = FREQ_W + LOAD_W;

  // settings
  logic [FREQ_W-1:0] freq_min, freq_max, ideal_freq, step_up, step_down;
  logic [LOAD_W-1:0] load_high, load_low;
  logic [TIME_W-1:0] up_hold_us;

  // captured request
  logic [TIME_W-1:0] idle_us, elapsed_us, now_r;
  logic [FREQ_W-1:0] cur;
  logic              many;

  // divider and working values
  logic [DIV_DEN_W-1:0] dv_rem, dv_den;
  logic [DIV_NUM_W-1:0] dv_quo;
  logic [LOAD_W-1:0]    load_r;
  step_dir_t            dir_r;
  logic [FREQ_W:0]      newf;
  logic [TIME_W-1:0]    last_change;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_min   <= FMIN_RST;
      freq_max   <= FMAX_RST;
      ideal_freq <= IDEAL_RST;
      step_up    <= SUP_RST;
      step_down  <= SDN_RST;
      load_high  <= LOAD_W'(50);
      load_low   <= LOAD_W'(25);
      up_hold_us <= 32'd48000;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FREQ_MIN:   freq_min   <= cfg_data[FREQ_W-1:0];
        REG_FREQ_MAX:   freq_max   <= cfg_data[FREQ_W-1:0];
        REG_IDEAL_FREQ: ideal_freq <= cfg_data[FREQ_W-1:0];
        REG_STEP_UP:    step_up    <= cfg_data[FREQ_W-1:0];
        REG_STEP_DOWN:  step_down  <= cfg_data[FREQ_W-1:0];
        REG_LOAD_HIGH:  load_high  <= cfg_data[LOAD_W-1:0];
        REG_LOAD_LOW:   load_low   <= cfg_data[LOAD_W-1:0];
        REG_UP_HOLD_US: up_hold_us <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // load numerator: 100 * busy time, zero when idle exceeds elapsed
  logic [TIME_W-1:0]    busy;
  logic                 idle_le;
  logic [DIV_NUM_W-1:0] scaled;

  assign idle_le = idle_us <= elapsed_us;
  assign busy    = elapsed_us - idle_us;
  assign scaled  = (DIV_NUM_W'(busy) << 6) + (DIV_NUM_W'(busy) << 5)
                 + (DIV_NUM_W'(busy) << 2);

  // one restoring step
  logic [DIV_DEN_W:0] shifted, trial;
  logic               fits;

  assign shifted = {dv_rem, dv_quo[DIV_NUM_W-1]};
  assign fits    = shifted >= {1'b0, dv_den};
  assign trial   = shifted - {1'b0, dv_den};

  // decision
  logic [LOAD_W-1:0] loadv;
  logic [FREQ_W-1:0] ideal;
  logic [TIME_W-1:0] since;
  logic              up_load, go_up, go_down;
  step_dir_t         dir_c;
  logic [FREQ_W:0]   newf_c;

  assign loadv   = dv_quo[LOAD_W-1:0];
  assign ideal   = (freq_min < ideal_freq)
                 ? ((ideal_freq < freq_max) ? ideal_freq : freq_max) : freq_min;
  assign since   = now_r - last_change;
  assign up_load = (loadv > load_high) || (idle_us == '0);
  assign go_up   = up_load && (cur < freq_max)
                 && ((cur < ideal) || (idle_us == '0) || (since >= up_hold_us));
  assign go_down = !up_load && (loadv < load_low) && (cur > freq_min)
                 && ((cur > ideal) || (since >= DOWN_HOLD_US));

  always_comb begin
    dir_c  = DIR_HOLD;
    newf_c = {1'b0, cur};
    if (go_up) begin
      dir_c = DIR_UP;
      if (many) begin
        if (cur < ideal)        newf_c = {1'b0, ideal};
        else if (step_up != '0) newf_c = {1'b0, cur} + {1'b0, step_up};
        else                    newf_c = {1'b0, freq_max};
      end
    end else if (go_down) begin
      dir_c = DIR_DOWN;
      if (cur > ideal)               newf_c = {1'b0, ideal};
      else if (step_down != '0)      newf_c = (cur > step_down)
                                            ? {1'b0, cur - step_down} : '0;
    end
  end

  assign status.short_tick = elapsed_us < MIN_ELAPSED_US;
  assign status.need_prop  = go_down && !(cur > ideal) && (step_down == '0);
  assign status.out_free   = !out_valid || out_ready;

  // proportional step and fix-up
  logic [PROD_W-1:0]    prod;
  logic [DIV_DEN_W-1:0] prop_den;
  logic [FREQ_W-1:0]    cur_dec;

  assign prod     = PROD_W'(cur) * PROD_W'(load_r);
  assign prop_den = (load_high == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(load_high);
  assign cur_dec  = (cur == '0) ? '0 : cur - 1'b1;

  // final clamp
  logic [FREQ_W-1:0] clamped, target_c;
  logic              chg_c;

  assign clamped  = (newf > {1'b0, freq_max}) ? freq_max
                  : (newf < {1'b0, freq_min}) ? freq_min : newf[FREQ_W-1:0];
  assign chg_c    = !status.short_tick && (newf != {1'b0, cur}) && (clamped != cur);
  assign target_c = chg_c ? clamped : cur;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idle_us    <= idle_delta_us;
      elapsed_us <= elapsed_delta_us;
      now_r      <= now_us;
      cur        <= cur_freq;
      many       <= many_runnable;
    end
    if (cmd.load_div_start) begin
      dv_quo <= idle_le ? scaled : '0;
      dv_rem <= '0;
      dv_den <= elapsed_us;
    end else if (cmd.prop_start) begin
      dv_quo <= DIV_NUM_W'(prod);
      dv_rem <= '0;
      dv_den <= prop_den;
    end else if (cmd.div_step) begin
      dv_rem <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      dv_quo <= {dv_quo[DIV_NUM_W-2:0], fits};
    end
    if (cmd.decide) begin
      load_r <= loadv;
      dir_r  <= dir_c;
      newf   <= newf_c;
    end else if (cmd.prop_fix) begin
      newf <= (dv_quo > DIV_NUM_W'(cur)) ? {1'b0, cur_dec} : dv_quo[FREQ_W:0];
    end
    if (cmd.load_out) begin
      out_chosen_freq   <= target_c;
      out_changed       <= chg_c;
      out_step_dir      <= status.short_tick ? DIR_HOLD : dir_r;
      out_load_pct      <= status.short_tick ? '0 : load_r;
      out_skipped       <= status.short_tick;
      out_keep_sampling <= status.short_tick || (target_c < freq_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      last_change <= '0;
    end else begin
      if (cmd.load_out)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.load_out && chg_c) last_change <= now_r;
    end
  end

  a_hold_no_change: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_step_dir == DIR_HOLD) |-> !out_changed)
    else $error("held decision reports a frequency change");

  a_skip_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_skipped) |-> (out_keep_sampling && out_load_pct == '0))
    else $error("skipped result carries a decision");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_chosen_freq)))
    else $error("stalled result dropped or changed");

endmodule

// ===== design/load_based_freq_governor_unit.sv =====
// Top level of the load-based frequency governor: stream ports, settings port and packing.
`timescale 1ns / 1ps
// Each request is one sampling tick; the block answers with exactly one result.
// A tick with under 1000 us elapsed is answered as skipped. Any other tick
// needs the load percent, worked out by a shared 39-step bit-serial restoring
// divider, and passes through the check, the load divide and the decision
// before its result sits in the output register. A ramp-down from at or below
// the ideal frequency with step_down of zero reuses that divider for
// cur_freq*load/load_high in a second divide and a fix-up. One request is in
// work at a time, and the next one is accepted in the cycle after the previous
// result has moved into the output register, even while that result still
// waits on m_axis_tready. Settings are written through the cfg port, which is
// always ready; write them only while no tick is in flight. The time of the
// last frequency change is held inside and cleared by reset.
module load_based_freq_governor_unit import lbfg_pkg::*; #(
  parameter int unsigned FREQ_BITS = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  // idle_delta_us, elapsed_delta_us, now_us, cur_freq, many_runnable, zero pad
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [((3*TIME_W + FREQ_BITS + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // chosen_freq, changed, step_dir, load_pct, keep_sampling, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [((FREQ_BITS + 1 + 2 + LOAD_W + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // skipped
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned OUT_DATA_W = ((FREQ_BITS + 1 + 2 + LOAD_W + 1 + 7) / 8) * 8;
  localparam int unsigned CUR_LSB    = 3 * TIME_W;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [FREQ_BITS-1:0] chosen_freq;
  logic                 changed, keep_sampling;
  step_dir_t            step_dir;
  logic [LOAD_W-1:0]    load_pct;

  // Settings never stall.
  assign cfg_ready = 1'b1;

  lbfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lbfg_dp #(
    .FREQ_W (FREQ_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .idle_delta_us     (s_axis_tdata[TIME_W-1:0]),
    .elapsed_delta_us  (s_axis_tdata[2*TIME_W-1:TIME_W]),
    .now_us            (s_axis_tdata[3*TIME_W-1:2*TIME_W]),
    .cur_freq          (s_axis_tdata[CUR_LSB+FREQ_BITS-1:CUR_LSB]),
    .many_runnable     (s_axis_tdata[CUR_LSB+FREQ_BITS]),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (m_axis_tready),
    .out_valid         (m_axis_tvalid),
    .out_chosen_freq   (chosen_freq),
    .out_changed       (changed),
    .out_step_dir      (step_dir),
    .out_load_pct      (load_pct),
    .out_skipped       (m_axis_tuser),
    .out_keep_sampling (keep_sampling)
  );

  // Pack the result fields from bit 0 up and pad with zeros.
  assign m_axis_tdata = OUT_DATA_W'({keep_sampling, load_pct, step_dir, changed, chosen_freq});

endmodule
